// ===== design/bto_pkg.sv =====
// Shared types, constants and helpers for the binomial tree option pricer.
// No dependencies.
`default_nettype none
package bto_pkg;

	typedef logic [31:0] price_t;
	typedef logic [30:0] frac_t;

	localparam frac_t Q30_ONE = 31'h4000_0000;
	localparam price_t PRICE_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CFG_STEPS = 3'd0,
		CFG_KIND  = 3'd1,
		CFG_UP    = 3'd2,
		CFG_DOWN  = 3'd3,
		CFG_PROB  = 3'd4,
		CFG_DISC  = 3'd5,
		CFG_UPPER = 3'd6,
		CFG_LOWER = 3'd7
	} cfg_idx_t;

	localparam logic [1:0] KIND_PUT     = 2'd1;
	localparam logic [1:0] KIND_BARRIER = 2'd2;

	// one entry of the up/down chain memory
	typedef struct packed {
		logic   up_cl;
		price_t up;
		logic   dn_cl;
		price_t dn;
	} chain_t;

	// per-request arithmetic settings, already clamped
	typedef struct packed {
		logic   barrier;
		logic   put;
		frac_t  q;
		frac_t  qc;
		frac_t  disc;
		price_t upper;
		price_t lower;
		price_t strike;
	} calc_cfg_t;

	// node pipeline status back to the sequencer
	typedef struct packed {
		logic   busy;
		logic   wrote;
		logic   sat_hit;
		price_t value;
	} pipe_stat_t;

	// (a*b)>>30 with clamp; bit 32 flags the clamp
	function automatic logic [32:0] mul_q30_sat(input price_t a, input price_t b);
		logic [63:0] p;
		logic [33:0] sh;
		p  = {32'b0, a} * {32'b0, b};
		sh = p[63:30];
		if (|sh[33:32]) begin
			mul_q30_sat = {1'b1, PRICE_MAX};
		end else begin
			mul_q30_sat = {1'b0, sh[31:0]};
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/bto_channels.sv =====
// Request and response channel interfaces.
// Valid/ready handshake with payload; no dependencies.
`default_nettype none
interface bto_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] spot_price;
	logic [31:0] strike;
	modport source(output valid, output spot_price, output strike, input ready);
	modport sink(input valid, input spot_price, input strike, output ready);
endinterface

interface bto_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] option_price;
	logic        saturated;
	modport source(output valid, output option_price, output saturated, input ready);
	modport sink(input valid, input option_price, input saturated, output ready);
endinterface
`default_nettype wire

// ===== design/binomial_tree_option_pricer.sv =====
// Top level of the CRR binomial tree option pricer.
// Uses bto_pkg, bto_channels, bto_chain_gen and bto_node_pipe.
`default_nettype none
// Prices one European option per request (spot, strike) by backward
// induction over a recombining binomial tree with n = min(steps, MAX_STEPS)
// levels. A request runs one at a time: the up/down factor chains are built
// into the chain memory at one entry per cycle (n+1 entries), the n+1
// leaves are priced, then each level L = n-1 .. 0 updates L+1 entries of
// the node memory at one node per cycle. The node pipeline is four stages
// deep and is drained between levels, since a level reads what the previous
// one wrote.
// A new request is taken in idle while the last response still waits.
// Prices are unsigned Q16.16, factors Q2.30, q and discount Q1.30.
// Configuration writes must be made only while no request is in flight;
// the block itself does not enforce this.
module binomial_tree_option_pricer #(
	parameter int MAX_STEPS = 1023
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata,
	bto_req_if.sink          req,
	bto_rsp_if.source        rsp
);
	localparam int AW = $clog2(MAX_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAIN,
		ST_LEAF,
		ST_BACK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// configuration registers
	logic [9:0]       steps_q;
	logic [1:0]       kind_q;
	bto_pkg::price_t  up_q, down_q, upper_q, lower_q;
	bto_pkg::frac_t   prob_q, disc_q;

	state_t           state_q;
	logic [AW-1:0]    n_q, lvl_q, idx_q;
	logic             sat_q;
	bto_pkg::price_t  last_q;
	bto_pkg::price_t  strike_q;
	logic             ov_q;
	bto_pkg::price_t  oprice_q;
	logic             osat_q;

	logic             accept;
	logic [AW-1:0]    n_eff;
	bto_pkg::frac_t   q_eff;
	bto_pkg::calc_cfg_t calc;
	bto_pkg::pipe_stat_t stat;

	logic             cw_we;
	logic [AW-1:0]    cw_addr;
	bto_pkg::chain_t  cw_data;
	logic             chain_done;
	logic             iss_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 10'd8;
			kind_q  <= 2'd0;
			up_q    <= 32'd1181116006;
			down_q  <= 32'd966367641;
			prob_q  <= 31'd536870912;
			disc_q  <= 31'd1073741824;
			upper_q <= 32'hFFFF_FFFF;
			lower_q <= 32'd0;
		end else if (cfg_we) begin
			case (bto_pkg::cfg_idx_t'(cfg_idx))
				bto_pkg::CFG_STEPS: steps_q <= cfg_wdata[9:0];
				bto_pkg::CFG_KIND:  kind_q  <= cfg_wdata[1:0];
				bto_pkg::CFG_UP:    up_q    <= cfg_wdata;
				bto_pkg::CFG_DOWN:  down_q  <= cfg_wdata;
				bto_pkg::CFG_PROB:  prob_q  <= cfg_wdata[30:0];
				bto_pkg::CFG_DISC:  disc_q  <= cfg_wdata[30:0];
				bto_pkg::CFG_UPPER: upper_q <= cfg_wdata;
				bto_pkg::CFG_LOWER: lower_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// step count is capped at MAX_STEPS
	always_comb begin
		if ({22'b0, steps_q} > 32'(MAX_STEPS)) begin
			n_eff = AW'(MAX_STEPS);
		end else begin
			n_eff = AW'(steps_q);
		end
	end

	// q and discount above one act as one; kind 3 prices a call
	assign q_eff        = (prob_q > bto_pkg::Q30_ONE) ? bto_pkg::Q30_ONE : prob_q;
	assign calc.q       = q_eff;
	assign calc.qc      = bto_pkg::Q30_ONE - q_eff;
	assign calc.disc    = (disc_q > bto_pkg::Q30_ONE) ? bto_pkg::Q30_ONE : disc_q;
	assign calc.barrier = (kind_q == bto_pkg::KIND_BARRIER);
	assign calc.put     = (kind_q == bto_pkg::KIND_PUT);
	assign calc.upper   = upper_q;
	assign calc.lower   = lower_q;
	assign calc.strike  = strike_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign iss_valid = (state_q == ST_LEAF) || (state_q == ST_BACK);

	bto_chain_gen #(.AW(AW)) u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.spot        (req.spot_price),
		.up_factor   (up_q),
		.down_factor (down_q),
		.n_last      (n_eff),
		.cw_we       (cw_we),
		.cw_addr     (cw_addr),
		.cw_data     (cw_data),
		.done        (chain_done)
	);

	bto_node_pipe #(.AW(AW)) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (calc),
		.cw_we     (cw_we),
		.cw_addr   (cw_addr),
		.cw_data   (cw_data),
		.iss_valid (iss_valid),
		.iss_leaf  (state_q == ST_LEAF),
		.iss_idx   (idx_q),
		.iss_lvl   (lvl_q),
		.stat      (stat)
	);

	// sequencer: chain build, leaves, one drained pass per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			lvl_q    <= '0;
			idx_q    <= '0;
			sat_q    <= 1'b0;
			last_q   <= '0;
			strike_q <= '0;
			ov_q     <= 1'b0;
			oprice_q <= '0;
			osat_q   <= 1'b0;
		end else begin
			if (stat.wrote) begin
				last_q <= stat.value;
			end
			if (stat.sat_hit) begin
				sat_q <= 1'b1;
			end
			// finish handles the response register itself
			if (ov_q && rsp.ready && state_q != ST_FINISH) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q      <= n_eff;
						strike_q <= req.strike;
						sat_q    <= 1'b0;
						state_q  <= ST_CHAIN;
					end
				end
				ST_CHAIN: begin
					if (chain_done) begin
						lvl_q   <= n_q;
						idx_q   <= '0;
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF, ST_BACK: begin
					if (idx_q == lvl_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						if (lvl_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							lvl_q   <= lvl_q - 1'b1;
							idx_q   <= '0;
							state_q <= ST_BACK;
						end
					end
				end
				ST_FINISH: begin
					if (!ov_q || rsp.ready) begin
						ov_q     <= 1'b1;
						oprice_q <= last_q;
						osat_q   <= sat_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.option_price = oprice_q;
	assign rsp.saturated    = osat_q;
endmodule
`default_nettype wire

// ===== design/bto_chain_gen.sv =====
// Builds the up and down factor chains, one entry per cycle.
// Uses bto_pkg; writes into the chain memory of bto_node_pipe.
`default_nettype none
module bto_chain_gen #(
	parameter int AW = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bto_pkg::price_t  spot,
	input  wire bto_pkg::price_t  up_factor,
	input  wire bto_pkg::price_t  down_factor,
	input  wire logic [AW-1:0]    n_last,
	output logic                  cw_we,
	output logic [AW-1:0]         cw_addr,
	output bto_pkg::chain_t       cw_data,
	output logic                  done
);
	logic            active_q;
	logic            done_q;
	logic [AW-1:0]   k_q;
	bto_pkg::chain_t cur_q;
	logic [32:0]     up_nx;
	logic [32:0]     dn_nx;

	assign up_nx = bto_pkg::mul_q30_sat(cur_q.up, up_factor);
	assign dn_nx = bto_pkg::mul_q30_sat(cur_q.dn, down_factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			k_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (active_q) begin
				if (k_q == n_last) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	// payload: chain running values
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= '{up_cl: 1'b0, up: spot, dn_cl: 1'b0, dn: {1'b0, bto_pkg::Q30_ONE}};
		end else if (active_q) begin
			cur_q.up    <= up_nx[31:0];
			cur_q.up_cl <= cur_q.up_cl | up_nx[32];
			cur_q.dn    <= dn_nx[31:0];
			cur_q.dn_cl <= cur_q.dn_cl | dn_nx[32];
		end
	end

	assign cw_we   = active_q;
	assign cw_addr = k_q;
	assign cw_data = cur_q;
	assign done    = done_q;
endmodule
`default_nettype wire

// ===== design/bto_node_pipe.sv =====
// Node update pipeline around the chain memory and the node value memory.
// Uses bto_pkg; issue control comes from the top-level sequencer.
`default_nettype none
module bto_node_pipe #(
	parameter int AW = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bto_pkg::calc_cfg_t  cfg,
	input  wire logic                cw_we,
	input  wire logic [AW-1:0]       cw_addr,
	input  wire bto_pkg::chain_t     cw_data,
	input  wire logic                iss_valid,
	input  wire logic                iss_leaf,
	input  wire logic [AW-1:0]       iss_idx,
	input  wire logic [AW-1:0]       iss_lvl,
	output bto_pkg::pipe_stat_t      stat
);
	localparam int DEPTH = 2 ** AW;

	bto_pkg::chain_t chain_mem [DEPTH];
	bto_pkg::price_t node_mem  [DEPTH];

	logic [AW-1:0] dn_addr;
	logic [AW-1:0] nb_addr;

	// stage 1: registered memory reads
	logic            v_s1, leaf_s1;
	logic [AW-1:0]   idx_s1;
	bto_pkg::chain_t ca_s1, cb_s1;
	bto_pkg::price_t pa_s1, pb_s1;
	// stage 2: products
	logic            v_s2, leaf_s2, cl_s2;
	logic [AW-1:0]   idx_s2;
	logic [63:0]     pm_s2, pu_s2, pd_s2;
	// stage 3: node price, payoff, expectation
	logic            v_s3, leaf_s3, knock_s3, sat_s3;
	logic [AW-1:0]   idx_s3;
	bto_pkg::price_t pay_s3, e_s3;
	// stage 4: discounted
	logic            v_s4, leaf_s4, knock_s4, sat_s4;
	logic [AW-1:0]   idx_s4;
	bto_pkg::price_t pay_s4;
	logic [63:0]     m_s4;

	logic [33:0]     s_sh;
	logic            s_ovf;
	bto_pkg::price_t s_px;
	logic            s_knock;
	logic [63:0]     e_sum;
	bto_pkg::price_t pay_nx;
	bto_pkg::price_t wr_value;

	assign dn_addr = iss_lvl - iss_idx;
	assign nb_addr = iss_idx + 1'b1;

	always_ff @(posedge clk) begin
		if (cw_we) begin
			chain_mem[cw_addr] <= cw_data;
		end
		ca_s1 <= chain_mem[iss_idx];
		cb_s1 <= chain_mem[dn_addr];
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			node_mem[idx_s4] <= wr_value;
		end
		pa_s1 <= node_mem[iss_idx];
		pb_s1 <= node_mem[nb_addr];
	end

	// node price, knock-out and leaf payoff
	always_comb begin
		s_sh    = pm_s2[63:30];
		s_ovf   = |s_sh[33:32];
		s_px    = s_ovf ? bto_pkg::PRICE_MAX : s_sh[31:0];
		s_knock = cfg.barrier && (s_px >= cfg.upper || s_px <= cfg.lower);
		e_sum   = pu_s2 + pd_s2;
		if (cfg.put) begin
			pay_nx = (cfg.strike > s_px) ? cfg.strike - s_px : '0;
		end else begin
			pay_nx = (s_px > cfg.strike) ? s_px - cfg.strike : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		leaf_s1 <= iss_leaf;
		idx_s1  <= iss_idx;

		leaf_s2 <= leaf_s1;
		idx_s2  <= idx_s1;
		cl_s2   <= ca_s1.up_cl | cb_s1.dn_cl;
		pm_s2   <= {32'b0, ca_s1.up} * {32'b0, cb_s1.dn};
		pu_s2   <= {33'b0, cfg.q} * {32'b0, pb_s1};
		pd_s2   <= {33'b0, cfg.qc} * {32'b0, pa_s1};

		leaf_s3  <= leaf_s2;
		idx_s3   <= idx_s2;
		knock_s3 <= s_knock;
		sat_s3   <= (cl_s2 | s_ovf) & (leaf_s2 | cfg.barrier);
		pay_s3   <= pay_nx;
		e_s3     <= e_sum[61:30];

		leaf_s4  <= leaf_s3;
		idx_s4   <= idx_s3;
		knock_s4 <= knock_s3;
		sat_s4   <= sat_s3;
		pay_s4   <= pay_s3;
		m_s4     <= {32'b0, e_s3} * {33'b0, cfg.disc};
	end

	always_comb begin
		if (knock_s4) begin
			wr_value = '0;
		end else if (leaf_s4) begin
			wr_value = pay_s4;
		end else begin
			wr_value = m_s4[61:30];
		end
	end

	assign stat.busy    = v_s1 | v_s2 | v_s3 | v_s4;
	assign stat.wrote   = v_s4;
	assign stat.sat_hit = v_s4 & sat_s4;
	assign stat.value   = wr_value;
endmodule
`default_nettype wire

// ===== design/bto_checker.sv =====
// Port-level checks for binomial_tree_option_pricer.
// Bound to the top level below; no package dependencies.
`default_nettype none
module bto_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_price,
	input wire logic        rsp_sat
);
	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_price) && $stable(rsp_sat))
		else $error("response changed while stalled");

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// no response can appear right after a request
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

	// a fresh response comes with the block back in idle
	a_idle_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("response while still busy");
endmodule

bind binomial_tree_option_pricer bto_checker u_bto_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_price (rsp.option_price),
	.rsp_sat   (rsp.saturated)
);
`default_nettype wire
